[sv/dbpc_pkg.sv]
// ---------------------------------------------------------------------------
// Button debounce and press classifier package
// Shared types and event codes for the debouncer datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package dbpc_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned DelayWidth = 16;
    localparam int unsigned CodeWidth  = 3;
    localparam int unsigned IndexWidth = 2;

    localparam logic [CodeWidth-1:0] EvIdle         = 3'd0;
    localparam logic [CodeWidth-1:0] EvShortPress   = 3'd1;
    localparam logic [CodeWidth-1:0] EvShortRelease = 3'd2;
    localparam logic [CodeWidth-1:0] EvLongPress    = 3'd3;
    localparam logic [CodeWidth-1:0] EvLongRelease  = 3'd4;

    localparam logic [IndexWidth-1:0] RegActiveLow   = 2'd0;
    localparam logic [IndexWidth-1:0] RegDebounceMs  = 2'd1;
    localparam logic [IndexWidth-1:0] RegLongPressMs = 2'd2;

    localparam logic [DelayWidth-1:0] DebounceReset  = 16'd20;
    localparam logic [DelayWidth-1:0] LongPressReset = 16'd500;

    typedef struct packed {
        logic                  invert_pin;
        logic [DelayWidth-1:0] debounce_ms;
        logic [DelayWidth-1:0] long_press_ms;
    } cfg_t;

    typedef struct packed {
        logic                 raw_pressed;
        logic [TimeWidth-1:0] last_change_time;
        logic                 stable_pressed;
        logic                 held;
        logic [TimeWidth-1:0] press_start_time;
        logic                 long_reported;
    } state_t;

endpackage

`default_nettype wire

[sv/dbpc_cfg.sv]
// ---------------------------------------------------------------------------
// Configuration register file
// Holds polarity, debounce time and long-press time, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module dbpc_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [dbpc_pkg::IndexWidth-1:0]    cfg_index,
    input  wire logic [dbpc_pkg::DelayWidth-1:0]    cfg_wdata,
    output dbpc_pkg::cfg_t                          cfg
);

    dbpc_pkg::cfg_t cfg_reg;
    dbpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dbpc_pkg::RegActiveLow:   cfg_next.invert_pin    = cfg_wdata[0];
                dbpc_pkg::RegDebounceMs:  cfg_next.debounce_ms   = cfg_wdata;
                dbpc_pkg::RegLongPressMs: cfg_next.long_press_ms = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_pin    <= 1'b1;
            cfg_reg.debounce_ms   <= dbpc_pkg::DebounceReset;
            cfg_reg.long_press_ms <= dbpc_pkg::LongPressReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/dbpc_eval.sv]
// ---------------------------------------------------------------------------
// Debounce and classification logic
// Computes the event code and the next state for one poll.
// ---------------------------------------------------------------------------
`default_nettype none

module dbpc_eval (
    input  wire dbpc_pkg::cfg_t                     cfg,
    input  wire dbpc_pkg::state_t                   state,
    input  wire logic                               pin_level,
    input  wire logic [dbpc_pkg::TimeWidth-1:0]     now_ms,
    output dbpc_pkg::state_t                        state_next,
    output logic [dbpc_pkg::CodeWidth-1:0]          code
);

    logic                             down;
    logic                             changed;
    logic [dbpc_pkg::TimeWidth-1:0]   since_change;
    logic [dbpc_pkg::TimeWidth-1:0]   since_press;
    logic                             settled;
    logic                             long_due;

    always_comb
    begin
        down         = cfg.invert_pin ? ~pin_level : pin_level;
        changed      = (down != state.raw_pressed);
        since_change = changed ? '0 : (now_ms - state.last_change_time);
        since_press  = now_ms - state.press_start_time;
        settled      = (since_change >= {16'd0, cfg.debounce_ms});
        long_due     = (since_press >= {16'd0, cfg.long_press_ms});

        state_next                  = state;
        state_next.raw_pressed      = down;
        state_next.last_change_time = changed ? now_ms : state.last_change_time;
        code                        = dbpc_pkg::EvIdle;

        if (settled)
        begin
            if (state.stable_pressed != down)
            begin
                state_next.stable_pressed = down;
                if (down)
                begin
                    state_next.held             = 1'b1;
                    state_next.press_start_time = now_ms;
                    state_next.long_reported    = 1'b0;
                    code                        = dbpc_pkg::EvShortPress;
                end
                else if (state.held)
                begin
                    code = state.long_reported ? dbpc_pkg::EvLongRelease
                                               : dbpc_pkg::EvShortRelease;
                    state_next.held          = 1'b0;
                    state_next.long_reported = 1'b0;
                end
            end
            else if (state.held && !state.long_reported && long_due)
            begin
                state_next.long_reported = 1'b1;
                code                     = dbpc_pkg::EvLongPress;
            end
        end
    end

endmodule

`default_nettype wire

[sv/button_debounce_press_classifier_core.sv]
// ---------------------------------------------------------------------------
// Button debounce and press classifier
// Debounces polled button samples and reports press and release events.
// ---------------------------------------------------------------------------
// Each input beat is one poll (pin level and millisecond timestamp) and yields
// exactly one output beat with an event code: idle, short press, short
// release, long press or long release. A poll is captured in an input register,
// classified against the debounce state combinationally and placed in an output
// register, so the block takes one beat per clock cycle when the output is not
// stalled; a stalled output holds the waiting poll in the input register.
`default_nettype none

module button_debounce_press_classifier_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [dbpc_pkg::IndexWidth-1:0]    cfg_index,
    input  wire logic [dbpc_pkg::DelayWidth-1:0]    cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               pin_level,
    input  wire logic [dbpc_pkg::TimeWidth-1:0]     now_ms,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [dbpc_pkg::CodeWidth-1:0]          event_code
);

    dbpc_pkg::cfg_t                     cfg;
    dbpc_pkg::state_t                   state_reg;
    dbpc_pkg::state_t                   state_next;
    logic [dbpc_pkg::CodeWidth-1:0]     code;

    logic                               in_valid_reg;
    logic                               pin_reg;
    logic [dbpc_pkg::TimeWidth-1:0]     now_reg;
    logic                               out_valid_reg;
    logic [dbpc_pkg::CodeWidth-1:0]     code_reg;
    logic                               advance;

    dbpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dbpc_eval u_eval (
        .cfg        (cfg),
        .state      (state_reg),
        .pin_level  (pin_reg),
        .now_ms     (now_reg),
        .state_next (state_next),
        .code       (code)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= pin_level;
            now_reg <= now_ms;
        end
        if (advance)
        begin
            code_reg <= code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = code_reg;

`ifndef NO_ASSERTIONS
    a_long_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.long_reported |-> state_reg.held)
        else $error("long press flagged without a held button");

    a_held_is_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held |-> state_reg.stable_pressed)
        else $error("held button with released debounced level");

    a_long_marks_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && code == dbpc_pkg::EvLongPress) |=> state_reg.long_reported)
        else $error("long press event did not mark the press as reported");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire

[tb/button_debounce_press_classifier_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button debounce and press classifier testbench
// Sends timestamped button polls through the valid/ready input channel,
// predicts each event code with a shadow debouncer kept in step with the
// configuration writes, and checks every output beat in order. A short
// directed sequence covers wrap-around, backward timestamps, zero delays and
// odd register writes; six random phases follow, each with its own settings
// and one of four patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------

module button_debounce_press_classifier_core_tb;

    localparam logic [dbpc_pkg::IndexWidth-1:0] RegUnmapped = 2'd3;
    localparam int unsigned PhaseCount   = 6;
    localparam int unsigned PhaseItems   = 165;
    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned PhaseInvert[PhaseCount]    = '{1, 0, 1, 0, 1, 0};
    localparam int unsigned PhaseDebounce[PhaseCount]  = '{20, 0, 65535, 5, 1, 12};
    localparam int unsigned PhaseLongPress[PhaseCount] = '{500, 0, 65535, 40, 0, 3};

    typedef struct {
        logic                           level;
        logic [dbpc_pkg::TimeWidth-1:0] stamp;
    } poll_t;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               cfg_write  = 1'b0;
    logic [dbpc_pkg::IndexWidth-1:0]    cfg_index  = '0;
    logic [dbpc_pkg::DelayWidth-1:0]    cfg_wdata  = '0;
    logic                               in_valid   = 1'b0;
    logic                               in_ready;
    logic                               pin_level  = 1'b0;
    logic [dbpc_pkg::TimeWidth-1:0]     now_ms     = '0;
    logic                               out_valid;
    logic                               out_ready  = 1'b0;
    logic [dbpc_pkg::CodeWidth-1:0]     event_code;

    poll_t                              poll_q[$];
    logic [dbpc_pkg::CodeWidth-1:0]     event_q[$];
    dbpc_pkg::cfg_t                     shadow_cfg = '{invert_pin: 1'b1,
                                                       debounce_ms: dbpc_pkg::DebounceReset,
                                                       long_press_ms: dbpc_pkg::LongPressReset};
    dbpc_pkg::state_t                   shadow_st  = '0;
    logic [dbpc_pkg::TimeWidth-1:0]     clock_ms   = '0;
    int unsigned                        idle_pct   = 0;
    int unsigned                        stall_pct  = 0;
    int unsigned                        n_queued   = 0;
    int unsigned                        n_checked  = 0;
    int unsigned                        error_count = 0;
    int unsigned                        cycle_count = 0;
    int unsigned                        ev_seen[5] = '{default: 0};

    button_debounce_press_classifier_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pin_level  (pin_level),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [dbpc_pkg::CodeWidth-1:0] classify_poll(
        input logic level, input logic [dbpc_pkg::TimeWidth-1:0] stamp);
        logic                           down;
        logic [dbpc_pkg::TimeWidth-1:0] settled_for;
        logic [dbpc_pkg::TimeWidth-1:0] held_for;
        logic [dbpc_pkg::CodeWidth-1:0] code;
        down = shadow_cfg.invert_pin ? ~level : level;
        code = dbpc_pkg::EvIdle;
        if (down != shadow_st.raw_pressed)
        begin
            shadow_st.raw_pressed      = down;
            shadow_st.last_change_time = stamp;
        end
        settled_for = stamp - shadow_st.last_change_time;
        held_for    = stamp - shadow_st.press_start_time;
        if (settled_for >= {16'd0, shadow_cfg.debounce_ms})
        begin
            if (shadow_st.stable_pressed != shadow_st.raw_pressed)
            begin
                shadow_st.stable_pressed = shadow_st.raw_pressed;
                if (shadow_st.stable_pressed)
                begin
                    shadow_st.held             = 1'b1;
                    shadow_st.press_start_time = stamp;
                    shadow_st.long_reported    = 1'b0;
                    code = dbpc_pkg::EvShortPress;
                end
                else if (shadow_st.held)
                begin
                    code = shadow_st.long_reported ? dbpc_pkg::EvLongRelease
                                                   : dbpc_pkg::EvShortRelease;
                    shadow_st.held          = 1'b0;
                    shadow_st.long_reported = 1'b0;
                end
            end
            else if (shadow_st.held && !shadow_st.long_reported &&
                     held_for >= {16'd0, shadow_cfg.long_press_ms})
            begin
                shadow_st.long_reported = 1'b1;
                code = dbpc_pkg::EvLongPress;
            end
        end
        return code;
    endfunction

    task automatic post_poll(input logic level, input logic [dbpc_pkg::TimeWidth-1:0] stamp);
        poll_t item;
        item.level = level;
        item.stamp = stamp;
        clock_ms = stamp;
        poll_q.insert(poll_q.size(), item);
        n_queued++;
    endtask

    task automatic post_step(input logic level, input logic [dbpc_pkg::TimeWidth-1:0] step);
        post_poll(level, clock_ms + step);
    endtask

    // Bouncy press, hold of random length, bouncy release; or 1-6 random polls.
    task automatic add_press_sequence();
        logic        down_lvl;
        int unsigned deb;
        int unsigned unit;
        int unsigned bounces;
        down_lvl = ~shadow_cfg.invert_pin;
        deb      = 32'(shadow_cfg.debounce_ms);
        unit     = (deb + 32'(shadow_cfg.long_press_ms)) / 6 + 1;
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(1, 6))
                post_step(1'($urandom_range(1)),
                          ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, unit));
        end
        else
        begin
            bounces = $urandom_range(0, 4);
            for (int k = 0; k < bounces; k++)
                post_step(k[0] ? ~down_lvl : down_lvl, $urandom_range(0, deb / 2));
            repeat ($urandom_range(2, 12))
                post_step(down_lvl, $urandom_range(0, unit));
            bounces = $urandom_range(0, 4);
            for (int k = 0; k < bounces; k++)
                post_step(k[0] ? down_lvl : ~down_lvl, $urandom_range(0, deb / 2));
            repeat ($urandom_range(2, 6))
                post_step(~down_lvl, $urandom_range(0, unit));
        end
    endtask

    task automatic write_reg(input logic [dbpc_pkg::IndexWidth-1:0] index,
                             input logic [dbpc_pkg::DelayWidth-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        case (index)
            dbpc_pkg::RegActiveLow:   shadow_cfg.invert_pin    = data[0];
            dbpc_pkg::RegDebounceMs:  shadow_cfg.debounce_ms   = data;
            dbpc_pkg::RegLongPressMs: shadow_cfg.long_press_ms = data;
            default:                  ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        poll_t head;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (poll_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                head = poll_q.pop_front();
                in_valid  <= 1'b1;
                pin_level <= head.level;
                now_ms    <= head.stamp;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [dbpc_pkg::CodeWidth-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                event_q.insert(event_q.size(), classify_poll(pin_level, now_ms));
            if (out_valid && out_ready)
            begin
                if (event_q.size() == 0)
                begin
                    $error("event_code beat %0d arrived with no poll pending", event_code);
                    error_count++;
                end
                else
                begin
                    want = event_q.pop_front();
                    if (event_code !== want)
                    begin
                        $error("event_code mismatch: expected %0d, got %0d", want, event_code);
                        error_count++;
                    end
                    if (want <= dbpc_pkg::EvLongRelease)
                        ev_seen[want]++;
                    n_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("button_debounce_press_classifier_core regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned target;
        int unsigned midway;
        bit          paused;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: active low, 20 ms debounce, 500 ms long press.
        @(negedge clk);
        post_poll(1'b1, 32'd0);
        post_poll(1'b0, 32'd10);
        post_poll(1'b0, 32'd30);
        post_poll(1'b0, 32'd529);
        post_poll(1'b0, 32'd530);
        post_poll(1'b1, 32'd540);
        post_poll(1'b1, 32'd560);
        post_poll(1'b0, 32'd600);
        post_poll(1'b1, 32'd605);
        post_poll(1'b1, 32'd625);
        post_poll(1'b0, 32'hFFFF_FFF0);
        post_poll(1'b0, 32'h0000_0004);
        post_poll(1'b1, 32'h0000_0010);
        post_poll(1'b1, 32'h0000_0000);
        post_poll(1'b1, 32'hFFFF_FFFF);
        wait (n_checked == n_queued);

        // Zero delays, an unmapped index, and polarity from the low bit only.
        write_reg(dbpc_pkg::RegDebounceMs, 16'd0);
        write_reg(dbpc_pkg::RegLongPressMs, 16'd0);
        write_reg(RegUnmapped, 16'hFFFF);
        write_reg(dbpc_pkg::RegActiveLow, 16'hFFFE);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        post_poll(1'b1, 32'd100);
        post_poll(1'b1, 32'd100);
        post_poll(1'b0, 32'd100);
        post_poll(1'b1, 32'd200);
        post_poll(1'b0, 32'd200);
        wait (n_checked == n_queued);
        write_reg(dbpc_pkg::RegActiveLow, 16'h0003);
        @(posedge clk);
        cfg_write <= 1'b0;

        paused = 1'b0;
        for (int p = 0; p < PhaseCount; p++)
        begin
            wait (n_checked == n_queued);
            write_reg(dbpc_pkg::RegActiveLow, 16'(PhaseInvert[p]));
            write_reg(dbpc_pkg::RegDebounceMs, 16'(PhaseDebounce[p]));
            write_reg(dbpc_pkg::RegLongPressMs, 16'(PhaseLongPress[p]));
            @(posedge clk);
            cfg_write <= 1'b0;
            @(negedge clk);
            idle_pct  = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 24 : 0;
            stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 24 : 0;
            target = n_queued + PhaseItems;
            midway = n_queued + PhaseItems / 2;
            while (n_queued < target)
            begin
                add_press_sequence();
                if (p == 3 && !paused && n_queued >= midway)
                begin
                    paused = 1'b1;
                    wait (n_checked == n_queued);
                    @(negedge clk);
                end
            end
        end

        wait (n_checked == n_queued);
        repeat (8) @(posedge clk);
        if (event_q.size() != 0)
        begin
            $error("%0d event_code beats never arrived", event_q.size());
            error_count++;
        end
        $display("Checked %0d polls under %0d random settings plus directed edge cases.",
                 n_checked, PhaseCount);
        $display("Events: idle %0d, short press %0d, short release %0d,",
                 ev_seen[dbpc_pkg::EvIdle], ev_seen[dbpc_pkg::EvShortPress],
                 ev_seen[dbpc_pkg::EvShortRelease]);
        $display("        long press %0d, long release %0d.",
                 ev_seen[dbpc_pkg::EvLongPress], ev_seen[dbpc_pkg::EvLongRelease]);
        if (error_count == 0)
            $display("button_debounce_press_classifier_core regression: pass");
        else
            $display("button_debounce_press_classifier_core regression: fail");
        $finish;
    end

endmodule

[sim.f]
sv/dbpc_pkg.sv
sv/dbpc_cfg.sv
sv/dbpc_eval.sv
sv/button_debounce_press_classifier_core.sv
tb/button_debounce_press_classifier_core_tb.sv
